@@ design/point_in_polygon_ray_test_defines.svh @@
// Assertion macros for the point-in-polygon top level.
// Included by the top level, which carries the concurrent checks; depends on nothing.
`ifndef POINT_IN_POLYGON_RAY_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pip_pkg.sv @@
// Shared types, widths, codes and the arctangent table of the point-in-polygon unit.
// Used by the top level, the CORDIC engine and the crossing tester; depends on nothing.
package pip_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam int CW  = 37;
	localparam int ZW  = 34;
	localparam int MW  = CW - 1;
	localparam int PW  = 38;

	localparam logic [23:0] KINV_Q24 = 24'd10187995;
	localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic               polygon_end;
	} req_beat_t;

	typedef struct packed {
		logic       inside_res;
		logic [1:0] status;
	} rsp_beat_t;

	typedef struct packed {
		logic               closes;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vtx_t;

	typedef struct packed {
		logic                 start;
		logic                 rotate;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cor_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [MW-1:0]        reach;
	} cor_rsp_t;

	typedef struct packed {
		logic                 start;
		logic signed [PW-1:0] ax;
		logic signed [PW-1:0] ay;
		logic signed [PW-1:0] bx;
		logic signed [PW-1:0] by;
		logic signed [PW-1:0] cx;
		logic signed [PW-1:0] cy;
		logic signed [PW-1:0] dx;
		logic signed [PW-1:0] dy;
	} cross_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} cross_rsp_t;

	function automatic logic [29:0] atan_at(input logic [5:0] i);
		logic [29:0] v;
		case (i)
			6'd0:  v = 30'd536870912;
			6'd1:  v = 30'd316933406;
			6'd2:  v = 30'd167458907;
			6'd3:  v = 30'd85004756;
			6'd4:  v = 30'd42667331;
			6'd5:  v = 30'd21354465;
			6'd6:  v = 30'd10679838;
			6'd7:  v = 30'd5340245;
			6'd8:  v = 30'd2670163;
			6'd9:  v = 30'd1335087;
			6'd10: v = 30'd667544;
			6'd11: v = 30'd333772;
			6'd12: v = 30'd166886;
			6'd13: v = 30'd83443;
			6'd14: v = 30'd41722;
			6'd15: v = 30'd20861;
			6'd16: v = 30'd10430;
			6'd17: v = 30'd5215;
			6'd18: v = 30'd2608;
			6'd19: v = 30'd1304;
			6'd20: v = 30'd652;
			6'd21: v = 30'd326;
			6'd22: v = 30'd163;
			6'd23: v = 30'd81;
			6'd24: v = 30'd41;
			6'd25: v = 30'd20;
			6'd26: v = 30'd10;
			6'd27: v = 30'd5;
			6'd28: v = 30'd3;
			6'd29: v = 30'd1;
			6'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ design/pip_cordic.sv @@
// Shared iterative CORDIC engine, vectoring for angle and distance, rotation for the ray end.
// One micro-rotation per cycle plus a registered gain multiply; depends on pip_pkg.
module pip_cordic #(
	parameter int CORDIC_STEPS = pip_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pip_pkg::cor_req_t req,
	output pip_pkg::cor_rsp_t rsp
);
	import pip_pkg::*;

	localparam int PRW = MW + 24;
	localparam logic [5:0] LAST_STEP = 6'(CORDIC_STEPS - 1);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_PRE  = 3'd1;
	localparam logic [2:0] C_RED  = 3'd2;
	localparam logic [2:0] C_ITER = 3'd3;
	localparam logic [2:0] C_POST = 3'd4;
	localparam logic [2:0] C_FIN  = 3'd5;

	logic [2:0]           state_q;
	logic                 rot_q;
	logic [5:0]           step_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [MW-1:0]        mul_a_q;
	logic [PRW-1:0]       prod_q;

	logic signed [CW-1:0] xs, ys, x_nx, y_nx, x0;
	logic signed [ZW-1:0] at, z_nx;
	logic                 ccw;
	logic [PRW-1:0]       prod_full;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = signed'(ZW'(atan_at(step_q)));
		ccw = rot_q ? !z_q[ZW-1] : y_q[CW-1];
		if (ccw) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - at;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + at;
		end
		prod_full = PRW'(mul_a_q) * PRW'(KINV_Q24);
		x0 = signed'(CW'(prod_q[PRW-1:24]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						rot_q <= req.rotate;
						step_q <= '0;
						if (req.rotate) begin
							mul_a_q <= req.x[MW-1:0];
							z_q <= req.z;
							state_q <= C_PRE;
						end else if (req.x == '0 && req.y == '0) begin
							prod_q <= '0;
							z_q <= '0;
							state_q <= C_FIN;
						end else begin
							if (req.x[CW-1]) begin
								x_q <= -req.x;
								y_q <= -req.y;
								z_q <= req.y[CW-1] ? -HALF_TURN : HALF_TURN;
							end else begin
								x_q <= req.x;
								y_q <= req.y;
								z_q <= '0;
							end
							state_q <= C_ITER;
						end
					end
				end
				C_PRE: begin
					prod_q <= prod_full;
					state_q <= C_RED;
				end
				C_RED: begin
					y_q <= '0;
					if (z_q > QUARTER_TURN) begin
						z_q <= z_q - HALF_TURN;
						x_q <= -x0;
					end else if (z_q < -QUARTER_TURN) begin
						z_q <= z_q + HALF_TURN;
						x_q <= -x0;
					end else begin
						x_q <= x0;
					end
					state_q <= C_ITER;
				end
				C_ITER: begin
					x_q <= x_nx;
					y_q <= y_nx;
					z_q <= z_nx;
					step_q <= step_q + 6'd1;
					mul_a_q <= x_nx[MW-1:0];
					if (step_q == LAST_STEP) begin
						state_q <= rot_q ? C_FIN : C_POST;
					end
				end
				C_POST: begin
					prod_q <= prod_full;
					state_q <= C_FIN;
				end
				C_FIN: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = (state_q == C_FIN);
	assign rsp.x     = x_q;
	assign rsp.y     = y_q;
	assign rsp.z     = z_q;
	assign rsp.reach = prod_q[PRW-1:24];

endmodule

@@ design/pip_cross.sv @@
// Exact strict segment crossing test from four orientation signs.
// Products are built from four 20x20 partial products each; depends on pip_pkg.
module pip_cross (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::cross_req_t req,
	output pip_pkg::cross_rsp_t rsp
);
	import pip_pkg::*;

	localparam int OW  = 40;
	localparam int HW  = OW / 2;
	localparam int PRW = 2 * OW;
	localparam int SW  = PRW + 2;

	localparam logic [2:0] X_IDLE = 3'd0;
	localparam logic [2:0] X_LOAD = 3'd1;
	localparam logic [2:0] X_PP   = 3'd2;
	localparam logic [2:0] X_ADD  = 3'd3;
	localparam logic [2:0] X_FIN  = 3'd4;

	logic [2:0]           state_q;
	logic [1:0]           side_q;
	logic                 half_q;
	logic [1:0]           pp_q;
	logic                 neg_q;
	logic [OW-1:0]        ma_q, mb_q;
	logic [PRW-1:0]       acc_q;
	logic signed [SW-1:0] sum_q;
	logic [3:0]           pos_q, negs_q;

	logic signed [PW-1:0] p1x, p1y, p2x, p2y, qx, qy;
	logic signed [OW-1:0] opa, opb;
	logic [HW-1:0]        pa, pb;
	logic [OW-1:0]        pp;
	logic [PRW-1:0]       term;
	logic signed [SW-1:0] prod_s, total;

	always_comb begin
		case (side_q)
			2'd0: begin
				p1x = req.cx; p1y = req.cy; p2x = req.dx; p2y = req.dy;
				qx = req.ax; qy = req.ay;
			end
			2'd1: begin
				p1x = req.cx; p1y = req.cy; p2x = req.dx; p2y = req.dy;
				qx = req.bx; qy = req.by;
			end
			2'd2: begin
				p1x = req.ax; p1y = req.ay; p2x = req.bx; p2y = req.by;
				qx = req.cx; qy = req.cy;
			end
			default: begin
				p1x = req.ax; p1y = req.ay; p2x = req.bx; p2y = req.by;
				qx = req.dx; qy = req.dy;
			end
		endcase
		if (half_q) begin
			opa = OW'(p1y) - OW'(p2y);
			opb = OW'(p1x) - OW'(qx);
		end else begin
			opa = OW'(p1x) - OW'(p2x);
			opb = OW'(qy) - OW'(p1y);
		end
		pa = pp_q[0] ? ma_q[OW-1:HW] : ma_q[HW-1:0];
		pb = pp_q[1] ? mb_q[OW-1:HW] : mb_q[HW-1:0];
		pp = OW'(pa) * OW'(pb);
		case (pp_q)
			2'd0:    term = PRW'(pp);
			2'd3:    term = PRW'(pp) << (2 * HW);
			default: term = PRW'(pp) << HW;
		endcase
		prod_s = neg_q ? -signed'(SW'(acc_q)) : signed'(SW'(acc_q));
		total = (half_q ? sum_q : '0) + prod_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
		end else begin
			case (state_q)
				X_IDLE: begin
					if (req.start) begin
						side_q <= '0;
						half_q <= 1'b0;
						state_q <= X_LOAD;
					end
				end
				X_LOAD: begin
					neg_q <= opa[OW-1] ^ opb[OW-1];
					ma_q <= opa[OW-1] ? OW'(-opa) : OW'(opa);
					mb_q <= opb[OW-1] ? OW'(-opb) : OW'(opb);
					acc_q <= '0;
					pp_q <= '0;
					state_q <= X_PP;
				end
				X_PP: begin
					acc_q <= acc_q + term;
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) begin
						state_q <= X_ADD;
					end
				end
				X_ADD: begin
					sum_q <= total;
					if (!half_q) begin
						half_q <= 1'b1;
						state_q <= X_LOAD;
					end else begin
						half_q <= 1'b0;
						pos_q[side_q] <= !total[SW-1] && (total != '0);
						negs_q[side_q] <= total[SW-1];
						if (side_q == 2'd3) begin
							state_q <= X_FIN;
						end else begin
							side_q <= side_q + 2'd1;
							state_q <= X_LOAD;
						end
					end
				end
				X_FIN: begin
					state_q <= X_IDLE;
				end
				default: begin
					state_q <= X_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (state_q == X_FIN);
	assign rsp.hit  = ((pos_q[0] && negs_q[1]) || (negs_q[0] && pos_q[1])) &&
		((pos_q[2] && negs_q[3]) || (negs_q[2] && pos_q[3]));

endmodule

@@ design/point_in_polygon_ray_test.sv @@
// Point-in-polygon unit: vertex table in one memory, ray casting per polygon on query.
// Top level; instantiates pip_cordic and pip_cross, depends on pip_pkg and the defines header.
//
// Use: requests arrive as beats on the req channel (req_valid, req_stall, req) and every
// request gives exactly one beat on the rsp channel (rsp_valid, rsp_stall, rsp).
// An append, a clear, an unknown request and a query on a never loaded table are answered
// from the output register in the cycle after acceptance.
// A query walks the stored vertices through the vertex memory, one vertex at a time. Each
// polygon of n vertices takes two vectoring passes per vertex, one rotation for the ray
// end and one crossing test per edge, all on the shared CORDIC engine and the
// partial-product multiplier of the crossing test; only one request is in work at a time.
// After reset the table is empty and not loaded; the memory needs no clearing.
// When the receiver stalls, the result waits in the output register and req_stall stays
// high until the register can take the next result.
module point_in_polygon_ray_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int CORDIC_STEPS = pip_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pip_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pip_pkg::rsp_beat_t rsp
);
	import pip_pkg::*;
	`include "point_in_polygon_ray_test_defines.svh"

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = AW + 1;
	localparam logic [CNTW-1:0] MAXV = CNTW'(MAX_VERTICES);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_P1_RD    = 4'd1;
	localparam logic [3:0] ST_P1_GO    = 4'd2;
	localparam logic [3:0] ST_P1_WAIT  = 4'd3;
	localparam logic [3:0] ST_P2_RD    = 4'd4;
	localparam logic [3:0] ST_P2_GO    = 4'd5;
	localparam logic [3:0] ST_P2_WAIT  = 4'd6;
	localparam logic [3:0] ST_ROT_GO   = 4'd7;
	localparam logic [3:0] ST_ROT_WAIT = 4'd8;
	localparam logic [3:0] ST_P3_RDC   = 4'd9;
	localparam logic [3:0] ST_P3_LDC   = 4'd10;
	localparam logic [3:0] ST_P3_LDD   = 4'd11;
	localparam logic [3:0] ST_P3_GO    = 4'd12;
	localparam logic [3:0] ST_P3_WAIT  = 4'd13;
	localparam logic [3:0] ST_DONE     = 4'd14;

	vtx_t vtx_mem [MAX_VERTICES];
	vtx_t rd_q;

	logic [3:0]           state_q;
	logic [CNTW-1:0]      vertex_total_q;
	logic                 table_loaded_q;
	logic                 rsp_valid_q;
	rsp_beat_t            rsp_q;
	logic signed [31:0]   px_q, py_q;
	logic [CNTW-1:0]      k_q, first_q, last_q;
	logic                 closes_q;
	logic signed [ZW-1:0] a0_q, a1_q;
	logic                 have_q;
	logic [MW-1:0]        maxd_q;
	logic signed [PW-1:0] tx_q, ty_q;
	vtx_t                 c_q, d_q;
	logic                 parity_q, inside_q;

	logic                 accept, out_free, wr_en, rsp_set;
	logic [CNTW-1:0]      k_nx, j_idx;
	logic [AW-1:0]        rd_addr;
	logic signed [ZW:0]   ang_sum;
	logic signed [ZW-1:0] ray;
	cor_req_t             cor_req;
	cor_rsp_t             cor_rsp;
	cross_req_t           cr_req;
	cross_rsp_t           cr_rsp;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign wr_en     = accept && (req.req_type == REQ_APPEND) && (vertex_total_q < MAXV);
	assign rsp_set   = (accept && !(req.req_type == REQ_QUERY && table_loaded_q)) ||
		(state_q == ST_DONE && out_free);

	assign k_nx    = k_q + 1'b1;
	assign j_idx   = (k_q == last_q) ? first_q : k_nx;
	assign rd_addr = (state_q == ST_P3_LDC) ? j_idx[AW-1:0] : k_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtx_mem[vertex_total_q[AW-1:0]] <= '{closes: req.polygon_end,
				y: req.y_coord, x: req.x_coord};
		end
		rd_q <= vtx_mem[rd_addr];
	end

	assign ang_sum = (ZW+1)'(a0_q) + (ZW+1)'(a1_q);
	assign ray     = have_q ? ang_sum[ZW:1] : '0;

	always_comb begin
		cor_req.start  = (state_q == ST_P1_GO) || (state_q == ST_P2_GO) ||
			(state_q == ST_ROT_GO);
		cor_req.rotate = (state_q == ST_ROT_GO);
		cor_req.z      = ray;
		if (state_q == ST_ROT_GO) begin
			cor_req.x = signed'(CW'({maxd_q[MW-2:0], 1'b0}));
			cor_req.y = '0;
		end else begin
			cor_req.x = CW'(rd_q.x) - CW'(px_q);
			cor_req.y = CW'(rd_q.y) - CW'(py_q);
		end
		cr_req.start = (state_q == ST_P3_GO);
		cr_req.ax = PW'(px_q);
		cr_req.ay = PW'(py_q);
		cr_req.bx = tx_q;
		cr_req.by = ty_q;
		cr_req.cx = PW'(c_q.x);
		cr_req.cy = PW'(c_q.y);
		cr_req.dx = PW'(d_q.x);
		cr_req.dy = PW'(d_q.y);
	end

	pip_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(cor_req),
		.rsp(cor_rsp)
	);

	pip_cross u_cross (
		.clk(clk),
		.arst_n(arst_n),
		.req(cr_req),
		.rsp(cr_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_set) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vertex_total_q <= '0;
			table_loaded_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_APPEND: begin
								if (vertex_total_q < MAXV) begin
									rsp_q <= '{inside_res: 1'b0, status: STAT_OK};
									vertex_total_q <= vertex_total_q + 1'b1;
									table_loaded_q <= 1'b1;
								end else begin
									rsp_q <= '{inside_res: 1'b0, status: STAT_FULL};
								end
							end
							REQ_CLEAR: begin
								rsp_q <= '{inside_res: 1'b0, status: STAT_OK};
								vertex_total_q <= '0;
								table_loaded_q <= 1'b1;
							end
							REQ_QUERY: begin
								if (!table_loaded_q) begin
									rsp_q <= '{inside_res: 1'b0, status: STAT_EMPTY};
								end else begin
									px_q <= req.x_coord;
									py_q <= req.y_coord;
									first_q <= '0;
									k_q <= '0;
									inside_q <= 1'b0;
									state_q <= (vertex_total_q == '0) ? ST_DONE : ST_P1_RD;
								end
							end
							default: begin
								rsp_q <= '{inside_res: 1'b0, status: STAT_OK};
							end
						endcase
					end
				end
				ST_P1_RD: begin
					state_q <= ST_P1_GO;
				end
				ST_P1_GO: begin
					closes_q <= rd_q.closes;
					state_q <= ST_P1_WAIT;
				end
				ST_P1_WAIT: begin
					if (cor_rsp.done) begin
						if (k_q == first_q || cor_rsp.z < a0_q) begin
							a0_q <= cor_rsp.z;
						end
						if (k_q == first_q || cor_rsp.reach > maxd_q) begin
							maxd_q <= cor_rsp.reach;
						end
						if (closes_q) begin
							last_q <= k_q;
							k_q <= first_q;
							have_q <= 1'b0;
							state_q <= ST_P2_RD;
						end else begin
							k_q <= k_nx;
							state_q <= (k_nx == vertex_total_q) ? ST_DONE : ST_P1_RD;
						end
					end
				end
				ST_P2_RD: begin
					state_q <= ST_P2_GO;
				end
				ST_P2_GO: begin
					state_q <= ST_P2_WAIT;
				end
				ST_P2_WAIT: begin
					if (cor_rsp.done) begin
						if (cor_rsp.z > a0_q && (!have_q || cor_rsp.z < a1_q)) begin
							a1_q <= cor_rsp.z;
							have_q <= 1'b1;
						end
						if (k_q == last_q) begin
							state_q <= ST_ROT_GO;
						end else begin
							k_q <= k_nx;
							state_q <= ST_P2_RD;
						end
					end
				end
				ST_ROT_GO: begin
					state_q <= ST_ROT_WAIT;
				end
				ST_ROT_WAIT: begin
					if (cor_rsp.done) begin
						tx_q <= PW'(px_q) + PW'(cor_rsp.x);
						ty_q <= PW'(py_q) + PW'(cor_rsp.y);
						k_q <= first_q;
						parity_q <= 1'b0;
						state_q <= ST_P3_RDC;
					end
				end
				ST_P3_RDC: begin
					state_q <= ST_P3_LDC;
				end
				ST_P3_LDC: begin
					c_q <= rd_q;
					state_q <= ST_P3_LDD;
				end
				ST_P3_LDD: begin
					d_q <= rd_q;
					state_q <= ST_P3_GO;
				end
				ST_P3_GO: begin
					state_q <= ST_P3_WAIT;
				end
				ST_P3_WAIT: begin
					if (cr_rsp.done) begin
						parity_q <= parity_q ^ cr_rsp.hit;
						if (k_q == last_q) begin
							inside_q <= inside_q | (parity_q ^ cr_rsp.hit);
							first_q <= k_nx;
							k_q <= k_nx;
							state_q <= (k_nx == vertex_total_q) ? ST_DONE : ST_P1_RD;
						end else begin
							k_q <= k_nx;
							state_q <= ST_P3_RDC;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q <= '{inside_res: inside_q, status: STAT_OK};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PIP_ASSERT_IMPLY(a_accept_only_idle, clk, arst_n, req_valid && !req_stall, state_q == ST_IDLE, "beat accepted while a query is in work")
	`PIP_ASSERT_IMPLY(a_total_bound, clk, arst_n, 1'b1, vertex_total_q <= MAXV, "vertex count beyond capacity")
	`PIP_ASSERT_NEXT(a_done_waits, clk, arst_n, state_q == ST_DONE && rsp_valid_q && rsp_stall, state_q == ST_DONE, "finished query dropped under stall")
	`PIP_ASSERT_IMPLY(a_inside_ok, clk, arst_n, rsp_valid, !rsp.inside_res || rsp.status == STAT_OK, "inside reported with an error status")

endmodule

@@ bench/pip_checker.sv @@
// Watches both channels of the point-in-polygon unit, predicts each response and compares it.
// Depends on pip_pkg for the beat types and codes; hands its failure count to the bench top.
`timescale 1ns / 100ps

module pip_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  pip_pkg::req_beat_t req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  pip_pkg::rsp_beat_t rsp,
	output int                 errors,
	output int                 pending,
	output int                 inside_hits
);
	import pip_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int STEPS = 24;
	localparam longint KINV = 10187995;
	localparam longint HALF = 64'sd2147483648;
	localparam longint QUARTER = 64'sd1073741824;

	longint atan_lut [0:23] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	int   tab_x [TABLE_DEPTH];
	int   tab_y [TABLE_DEPTH];
	bit   tab_end [TABLE_DEPTH];
	int   tab_count;
	bit   tab_loaded;
	rsp_beat_t answers [$];

	assign pending = answers.size();

	function automatic void angle_and_range(input longint dx, input longint dy,
			output longint ang, output longint reach);
		longint x, y, z, xs, ys;
		x = dx; y = dy; z = 0;
		if (dx == 0 && dy == 0) begin
			ang = 0; reach = 0;
			return;
		end
		if (dx < 0) begin
			x = -dx; y = -dy;
			z = (dy >= 0) ? HALF : -HALF;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_lut[i];
			end else begin
				x -= ys; y += xs; z -= atan_lut[i];
			end
		end
		ang = z;
		reach = (x * KINV) >>> 24;
	endfunction

	function automatic void ray_end(input longint len, input longint ang,
			output longint ox, output longint oy);
		longint x, y, z, xs, ys;
		x = (len * KINV) >>> 24; y = 0; z = ang;
		if (z > QUARTER) begin
			z -= HALF; x = -x;
		end else if (z < -QUARTER) begin
			z += HALF; x = -x;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_lut[i];
			end else begin
				x += ys; y -= xs; z += atan_lut[i];
			end
		end
		ox = x; oy = y;
	endfunction

	function automatic int side_of(input longint p1x, input longint p1y, input longint p2x,
			input longint p2y, input longint qx, input longint qy);
		logic signed [127:0] a1, a2, b1, b2, s;
		a1 = p1x - p2x; a2 = qy - p1y;
		b1 = p1y - p2y; b2 = p1x - qx;
		s = a1 * a2 + b1 * b2;
		if (s < 0) return -1;
		return (s != 0) ? 1 : 0;
	endfunction

	function automatic bit segments_cross(input longint ax, input longint ay, input longint bx,
			input longint by, input longint cx, input longint cy, input longint dx,
			input longint dy);
		if (side_of(cx, cy, dx, dy, ax, ay) * side_of(cx, cy, dx, dy, bx, by) >= 0)
			return 0;
		return side_of(ax, ay, bx, by, cx, cy) * side_of(ax, ay, bx, by, dx, dy) < 0;
	endfunction

	function automatic bit point_in_one(input longint px, input longint py, input int first,
			input int last);
		longint a0, a1, maxd, ang, reach, ox, oy, tx, ty;
		bit have_a1;
		int j, hits;
		a0 = 0; a1 = 0; maxd = 0; have_a1 = 0; hits = 0;
		for (int i = first; i <= last; i++) begin
			angle_and_range(tab_x[i] - px, tab_y[i] - py, ang, reach);
			if (i == first || ang < a0) a0 = ang;
			if (reach > maxd) maxd = reach;
		end
		for (int i = first; i <= last; i++) begin
			angle_and_range(tab_x[i] - px, tab_y[i] - py, ang, reach);
			if (ang > a0 && (!have_a1 || ang < a1)) begin
				a1 = ang; have_a1 = 1;
			end
		end
		ray_end(2 * maxd, have_a1 ? ((a0 + a1) >>> 1) : 0, ox, oy);
		tx = px + ox; ty = py + oy;
		for (int i = first; i <= last; i++) begin
			j = (i == last) ? first : i + 1;
			if (segments_cross(px, py, tx, ty, tab_x[i], tab_y[i], tab_x[j], tab_y[j]))
				hits++;
		end
		return hits[0];
	endfunction

	task automatic apply_request(input req_beat_t r);
		rsp_beat_t a;
		int start;
		a.inside_res = 0;
		a.status = STAT_OK;
		case (r.req_type)
			REQ_APPEND: begin
				if (tab_count >= TABLE_DEPTH) begin
					a.status = STAT_FULL;
				end else begin
					tab_x[tab_count] = r.x_coord;
					tab_y[tab_count] = r.y_coord;
					tab_end[tab_count] = r.polygon_end;
					tab_count++;
					tab_loaded = 1;
				end
			end
			REQ_CLEAR: begin
				tab_count = 0;
				tab_loaded = 1;
			end
			REQ_QUERY: begin
				if (!tab_loaded) begin
					a.status = STAT_EMPTY;
				end else begin
					start = 0;
					for (int i = 0; i < tab_count; i++) begin
						if (tab_end[i]) begin
							if (point_in_one(r.x_coord, r.y_coord, start, i))
								a.inside_res = 1;
							start = i + 1;
						end
					end
				end
			end
			default: ;
		endcase
		if (a.inside_res) inside_hits++;
		answers = {answers, a};
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			tab_count = 0;
			tab_loaded = 0;
			answers.delete();
			errors = 0;
			inside_hits = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answers.size() == 0) begin
					$display("%0t: unexpected response beat %p", $time, rsp);
					errors++;
				end else begin
					want = answers.pop_front();
					if (rsp.inside_res !== want.inside_res)
						$display("%0t: inside_res expected %0b actual %0b", $time,
							want.inside_res, rsp.inside_res);
					if (rsp.status !== want.status)
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp.status);
					if (rsp.inside_res !== want.inside_res || rsp.status !== want.status)
						errors++;
				end
			end
			if (req_valid && !req_stall)
				apply_request(req);
		end
	end
endmodule

@@ bench/testbench.sv @@
// Bench top for the point-in-polygon unit: clock, reset, request stimulus, response stalls.
// Depends on pip_pkg, the point_in_polygon_ray_test RTL and pip_checker.
`timescale 1ns / 100ps

module testbench;
	import pip_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam int RANDOM_ITEMS = 1750;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;
	int        errors;
	int        pending;
	int        inside_hits;
	longint    cycles = 0;
	int        sent;
	int        burst_left;
	bit        hold_off;
	int        queries;

	point_in_polygon_ray_test dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	pip_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending), .inside_hits(inside_hits)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL point_in_polygon_ray_test");
			$finish;
		end
	end

	initial begin
		int mode, span, wait_cycles;
		bit held;
		rsp_stall = 0;
		mode = 0; span = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				rsp_stall <= 1;
				wait_cycles = 0;
				while (wait_cycles < 400) begin
					@(posedge clk);
					wait_cycles++;
				end
				held = 1;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 300);
			end
			span--;
			case (mode)
				0: rsp_stall <= 0;
				1: rsp_stall <= ($urandom_range(0, 99) < 30);
				2: rsp_stall <= ($urandom_range(0, 99) < 85);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	task automatic send(input logic [1:0] kind, input int x, input int y, input bit last);
		bit stalled;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		req_valid <= 1;
		req <= '{req_type: kind, x_coord: x, y_coord: y, polygon_end: last};
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
		sent++;
		if (kind == REQ_QUERY) queries++;
	endtask

	function automatic int near(input int c, input int r);
		longint v;
		v = longint'(c) + longint'($urandom_range(0, 2 * r)) - r;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return int'(v);
	endfunction

	task automatic polygon(input int cx, input int cy, input int r);
		int n;
		n = $urandom_range(3, 6);
		for (int i = 0; i < n; i++)
			send(REQ_APPEND, near(cx, r), near(cy, r), i == n - 1);
	endtask

	initial begin
		int cx, cy, r, polys;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		sent = 0;
		queries = 0;
		burst_left = 0;
		hold_off = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(REQ_QUERY, 0, 0, 0);
		send(REQ_UNKNOWN, -1, -1, 1);
		send(REQ_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0);
		send(REQ_APPEND, 32'sh80000000, 32'sh7fffffff, 0);
		send(REQ_APPEND, 0, 32'sh80000000, 1);
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_QUERY, 32'sh7fffffff, 32'sh7fffffff, 1);
		send(REQ_QUERY, 32'sh80000000, 32'sh80000000, 0);
		send(REQ_CLEAR, 0, 0, 0);
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_APPEND, 0, 0, 0);
		send(REQ_APPEND, 32'sh000a0000, 0, 0);
		send(REQ_APPEND, 0, 32'sh000a0000, 1);
		send(REQ_QUERY, 32'sh00010000, 32'sh00010000, 0);
		send(REQ_QUERY, 32'sh00050000, 32'sh00050000, 0);
		send(REQ_QUERY, 32'sh00050000, 0, 0);
		send(REQ_QUERY, 32'sh00140000, 0, 0);
		send(REQ_APPEND, 32'sh00010000, 32'sh00010000, 0);
		send(REQ_QUERY, 32'sh00020000, 32'sh00020000, 0);
		send(REQ_UNKNOWN, 0, 0, 0);
		send(REQ_CLEAR, 0, 0, 0);

		for (int i = 0; i < 256; i++)
			send(REQ_APPEND, near(0, 1 << 22), near(0, 1 << 22), (i % 3 == 2) || i == 255);
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_APPEND, 5, 5, 1);
		send(REQ_QUERY, near(0, 1 << 20), near(0, 1 << 20), 0);
		send(REQ_CLEAR, 0, 0, 0);

		hold_off = 1;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) send(REQ_CLEAR, 0, 0, 0);
			case ($urandom_range(0, 3))
				0: r = $urandom_range(1, 1 << 16);
				1: r = $urandom_range(1 << 16, 1 << 24);
				2: r = $urandom_range(1 << 24, 1 << 29);
				default: r = $urandom_range(1, 64);
			endcase
			cx = near(0, 32'h3fffffff);
			cy = near(0, 32'h3fffffff);
			polys = $urandom_range(1, 3);
			for (int p = 0; p < polys; p++)
				polygon(near(cx, r), near(cy, r), r);
			if ($urandom_range(0, 4) == 0)
				send(REQ_APPEND, near(cx, r), near(cy, r), 0);
			repeat ($urandom_range(3, 10)) begin
				if ($urandom_range(0, 9) == 0)
					send(REQ_QUERY, $urandom, $urandom, $urandom_range(0, 1));
				else
					send(REQ_QUERY, near(cx, 2 * r), near(cy, 2 * r), $urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0)
				send(REQ_UNKNOWN, $urandom, $urandom, $urandom_range(0, 1));
		end
		req_valid <= 0;

		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d requests, %0d of them queries, %0d answered inside,",
			sent, queries, inside_hits);
		$display("with a full table, overflow, extremes and bursty, stalled channels.");
		if (errors == 0)
			$display("PASS point_in_polygon_ray_test");
		else
			$display("FAIL point_in_polygon_ray_test");
		$finish;
	end
endmodule

@@ point_in_polygon_ray_test.f @@
+incdir+design
design/pip_pkg.sv
design/pip_cordic.sv
design/pip_cross.sv
design/point_in_polygon_ray_test.sv
bench/pip_checker.sv
bench/testbench.sv
